// ----- design/vifp_pkg.sv -----
// Package for the VXLAN inner flow parser: protocol constants, header offsets,
// captured-field and result types, and big-endian byte insert helpers.
// No dependencies.
package vifp_pkg;

	// Frame offset counter width, fixed by the frame_length result field
	localparam int unsigned OFF_W = 16;
	localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

	// Protocol codes
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
	localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
	localparam logic [3:0]  IHL_MIN       = 4'd5;
	localparam logic [15:0] TUNNEL_PORT_RST = 16'd4789;

	// Fixed outer header offsets (bytes from frame start)
	localparam logic [15:0] OFF_ETH_TYPE    = 16'd12;
	localparam logic [15:0] OFF_OUTER_IHL   = 16'd14;
	localparam logic [15:0] OFF_OUTER_PROTO = 16'd23;
	localparam logic [15:0] OFF_OUTER_SRC   = 16'd26;
	localparam logic [15:0] OFF_OUTER_DST   = 16'd30;
	localparam logic [15:0] MIN_OUTER_BYTES = 16'd34;

	// Offsets relative to variable header starts
	localparam logic [7:0] ETH_HDR_LEN   = 8'd14;
	localparam logic [7:0] UDP_VXLAN_LEN = 8'd16;
	localparam logic [7:0] UDP_HDR_LEN   = 8'd8;
	localparam logic [7:0] TCP_HDR_LEN   = 8'd20;
	localparam logic [7:0] VNI_REL       = 8'd12;
	localparam logic [7:0] ITYPE_REL     = 8'd12;
	localparam logic [7:0] V6_NH_REL     = 8'd6;
	localparam logic [7:0] V4_PROTO_REL  = 8'd9;
	localparam logic [7:0] V4_SRC_REL    = 8'd12;
	localparam logic [7:0] V4_DST_REL    = 8'd16;
	localparam logic [7:0] V4_HDR_MIN    = 8'd20;
	localparam logic [7:0] V6_HDR_LEN    = 8'd40;

	// Header fields collected while the frame streams in
	typedef struct packed {
		logic [15:0] otype;
		logic [7:0]  oproto;
		logic [31:0] osrc;
		logic [31:0] odst;
		logic [31:0] ports;
		logic [23:0] vni;
		logic [15:0] itype;
		logic [7:0]  v4proto;
		logic [7:0]  v6proto;
		logic [31:0] isrc;
		logic [31:0] idst;
		logic [31:0] l4ports;
	} vifp_fields_t;

	// Frame view handed from capture to the end-of-frame check
	typedef struct packed {
		vifp_fields_t      fld;
		logic [OFF_W-1:0]  n;
		logic [7:0]        u_off;
		logic [7:0]        e_off;
		logic [7:0]        i_off;
		logic [7:0]        l_off;
		logic              rej;
	} vifp_frame_t;

	// Result beat payload; last member sits in the lowest bits
	typedef struct packed {
		logic [15:0] inner_length;
		logic [15:0] frame_length;
		logic [15:0] inner_dst_port;
		logic [15:0] inner_src_port;
		logic [31:0] inner_dst_addr;
		logic [31:0] inner_src_addr;
		logic [7:0]  inner_proto;
		logic [23:0] net_id;
		logic [31:0] outer_port_pair;
		logic [31:0] outer_dst_addr;
		logic [31:0] outer_src_addr;
	} vifp_result_t;

	localparam int unsigned TDATA_OUT_W = $bits(vifp_result_t);

	// Insert a byte into a big-endian word; position 0 is the most significant byte
	function automatic logic [15:0] put_be16(logic [15:0] old, logic k, logic [7:0] b);
		logic [15:0] r;
		r = old;
		if (k) r[7:0] = b;
		else r[15:8] = b;
		return r;
	endfunction

	function automatic logic [23:0] put_be24(logic [23:0] old, logic [1:0] k, logic [7:0] b);
		logic [23:0] r;
		r = old;
		case (k)
			2'd0: r[23:16] = b;
			2'd1: r[15:8]  = b;
			default: r[7:0] = b;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] put_be32(logic [31:0] old, logic [1:0] k, logic [7:0] b);
		logic [31:0] r;
		r = old;
		case (k)
			2'd0: r[31:24] = b;
			2'd1: r[23:16] = b;
			2'd2: r[15:8]  = b;
			default: r[7:0] = b;
		endcase
		return r;
	endfunction

endpackage

// ----- design/vifp_field_capture.sv -----
// Per-frame state of the VXLAN inner flow parser: byte offset counter, header
// lengths, reject flag and captured header bytes. Depends on vifp_pkg.
module vifp_field_capture #(
	parameter int unsigned MAX_FRAME_BYTES = vifp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           frame_byte,
	input  logic                 frame_end,
	output vifp_pkg::vifp_frame_t frame
);
	import vifp_pkg::*;

	logic [OFF_W-1:0] off_q, off_nx;
	logic [5:0]       ohl_q, ohl_nx, ihl_q, ihl_nx;
	logic             rej_q, rej_nx;
	vifp_fields_t     fld_q, fld_nx;
	logic             live, at_ohl, at_ihl, short_ihl;
	logic [7:0]       u_off, e_off, i_off, l_off;
	logic [OFF_W-1:0] d_otype, d_oproto, d_osrc, d_odst, d_ports, d_vni, d_itype;
	logic [OFF_W-1:0] d_v6p, d_v4p, d_isrc, d_idst, d_l4;

	// Header lengths and the offsets that follow from them
	always_comb begin
		live      = {1'b0, off_q} < (OFF_W+1)'(MAX_FRAME_BYTES);
		short_ihl = frame_byte[3:0] < IHL_MIN;
		at_ohl    = live && (off_q == OFF_OUTER_IHL);
		ohl_nx    = at_ohl ? {frame_byte[3:0], 2'b00} : ohl_q;
		u_off     = ETH_HDR_LEN + {2'b00, ohl_nx};
		e_off     = u_off + UDP_VXLAN_LEN;
		i_off     = e_off + ETH_HDR_LEN;
		at_ihl    = live && (off_q == {8'h00, i_off});
		ihl_nx    = at_ihl ? {frame_byte[3:0], 2'b00} : ihl_q;
		l_off     = i_off + {2'b00, ihl_nx};
		rej_nx    = rej_q || (at_ohl && short_ihl) ||
		            (at_ihl && fld_q.itype == ETH_TYPE_IPV4 && short_ihl);
		off_nx    = live ? off_q + 16'd1 : off_q;
	end

	// Distance of the current byte from each field start
	always_comb begin
		d_otype  = off_q - OFF_ETH_TYPE;
		d_oproto = off_q - OFF_OUTER_PROTO;
		d_osrc   = off_q - OFF_OUTER_SRC;
		d_odst   = off_q - OFF_OUTER_DST;
		d_ports  = off_q - {8'h00, u_off};
		d_vni    = off_q - {8'h00, u_off + VNI_REL};
		d_itype  = off_q - {8'h00, e_off + ITYPE_REL};
		d_v6p    = off_q - {8'h00, i_off + V6_NH_REL};
		d_v4p    = off_q - {8'h00, i_off + V4_PROTO_REL};
		d_isrc   = off_q - {8'h00, i_off + V4_SRC_REL};
		d_idst   = off_q - {8'h00, i_off + V4_DST_REL};
		d_l4     = off_q - {8'h00, l_off};
	end

	// Drop the byte into every field whose window covers it
	always_comb begin
		fld_nx = fld_q;
		if (live) begin
			if (d_otype < 16'd2) fld_nx.otype = put_be16(fld_q.otype, d_otype[0], frame_byte);
			if (d_oproto == 16'd0) fld_nx.oproto = frame_byte;
			if (d_osrc < 16'd4) fld_nx.osrc = put_be32(fld_q.osrc, d_osrc[1:0], frame_byte);
			if (d_odst < 16'd4) fld_nx.odst = put_be32(fld_q.odst, d_odst[1:0], frame_byte);
			if (d_ports < 16'd4) fld_nx.ports = put_be32(fld_q.ports, d_ports[1:0], frame_byte);
			if (d_vni < 16'd3) fld_nx.vni = put_be24(fld_q.vni, d_vni[1:0], frame_byte);
			if (d_itype < 16'd2) fld_nx.itype = put_be16(fld_q.itype, d_itype[0], frame_byte);
			if (d_v6p == 16'd0) fld_nx.v6proto = frame_byte;
			if (d_v4p == 16'd0) fld_nx.v4proto = frame_byte;
			if (d_isrc < 16'd4) fld_nx.isrc = put_be32(fld_q.isrc, d_isrc[1:0], frame_byte);
			if (d_idst < 16'd4) fld_nx.idst = put_be32(fld_q.idst, d_idst[1:0], frame_byte);
			if (d_l4 < 16'd4) fld_nx.l4ports = put_be32(fld_q.l4ports, d_l4[1:0], frame_byte);
		end
	end

	// Frame view including the current byte
	always_comb begin
		frame.fld   = fld_nx;
		frame.n     = off_nx;
		frame.u_off = u_off;
		frame.e_off = e_off;
		frame.i_off = i_off;
		frame.l_off = l_off;
		frame.rej   = rej_nx;
	end

	// Advance control state; clear it after the last beat of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			ohl_q <= '0;
			ihl_q <= '0;
			rej_q <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				off_q <= '0;
				ohl_q <= '0;
				ihl_q <= '0;
				rej_q <= 1'b0;
			end else begin
				off_q <= off_nx;
				ohl_q <= ohl_nx;
				ihl_q <= ihl_nx;
				rej_q <= rej_nx;
			end
		end
	end

	// Captured bytes; every field read at frame end was written in that frame
	always_ff @(posedge clk) begin
		if (step) begin
			fld_q <= fld_nx;
		end
	end

	a_off_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && frame_end |=> off_q == '0 && !rej_q)
		else $error("offset not cleared after frame end");

	a_off_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, off_q} <= (OFF_W+1)'(MAX_FRAME_BYTES))
		else $error("offset beyond frame limit");

	a_off_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && !frame_end && live |=> off_q == $past(off_q) + 16'd1)
		else $error("offset did not advance");

endmodule

// ----- design/vifp_frame_check.sv -----
// End-of-frame validation and result forming for the VXLAN inner flow parser.
// Depends on vifp_pkg.
module vifp_frame_check (
	input  vifp_pkg::vifp_frame_t  frame,
	input  logic [15:0]            tunnel_udp_port,
	output logic                   ok,
	output vifp_pkg::vifp_result_t res,
	output logic                   inner_is_v6
);
	import vifp_pkg::*;

	logic        outer_ok, v4, v6, l4, v4_ok, v6_ok, port_hit;
	logic [7:0]  u_need, v4_need, v6_need, l4_need;
	logic [15:0] n;

	// Length and header checks
	always_comb begin
		n        = frame.n;
		u_need   = frame.u_off + UDP_HDR_LEN;
		v4_need  = frame.i_off + V4_HDR_MIN;
		v6_need  = frame.i_off + V6_HDR_LEN;
		v4       = frame.fld.itype == ETH_TYPE_IPV4;
		v6       = frame.fld.itype == ETH_TYPE_IPV6;
		l4       = frame.fld.v4proto == IP_PROTO_TCP || frame.fld.v4proto == IP_PROTO_UDP;
		l4_need  = frame.l_off +
		           ((frame.fld.v4proto == IP_PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
		port_hit = frame.fld.ports[31:16] == tunnel_udp_port ||
		           frame.fld.ports[15:0] == tunnel_udp_port;
		outer_ok = !frame.rej && n >= MIN_OUTER_BYTES &&
		           frame.fld.otype == ETH_TYPE_IPV4 && frame.fld.oproto == IP_PROTO_UDP &&
		           n >= {8'h00, u_need} && port_hit && n >= {8'h00, frame.i_off};
		v4_ok    = n >= {8'h00, v4_need} && (!l4 || n >= {8'h00, l4_need});
		v6_ok    = n >= {8'h00, v6_need};
		ok       = outer_ok && ((v4 && v4_ok) || (v6 && v6_ok));
	end

	// Result fields; inner addresses and ports zero unless inner IPv4 carries them
	always_comb begin
		inner_is_v6         = v6;
		res.outer_src_addr  = frame.fld.osrc;
		res.outer_dst_addr  = frame.fld.odst;
		res.outer_port_pair = frame.fld.ports;
		res.net_id          = frame.fld.vni;
		res.inner_proto     = v6 ? frame.fld.v6proto : frame.fld.v4proto;
		res.inner_src_addr  = v6 ? 32'h0 : frame.fld.isrc;
		res.inner_dst_addr  = v6 ? 32'h0 : frame.fld.idst;
		res.inner_src_port  = (!v6 && l4) ? frame.fld.l4ports[31:16] : 16'h0;
		res.inner_dst_port  = (!v6 && l4) ? frame.fld.l4ports[15:0] : 16'h0;
		res.frame_length    = n;
		res.inner_length    = n - {8'h00, frame.e_off};
	end

endmodule

// ----- design/vxlan_inner_flow_parser_unit.sv -----
// Top level of the VXLAN inner flow parser: input beat register, result
// register, tunnel port register. Depends on vifp_pkg, vifp_field_capture,
// vifp_frame_check.
//
//  channel  | signals                                   | beat
//  s_axis   | tvalid tready tdata[7:0] tlast            | frame_byte, tlast = frame_end
//  m_axis   | tvalid tready tdata[255:0] tuser[0:0]     | one flow record per good frame
//  cfg      | cfg_we cfg_wdata[15:0]                    | tunnel_udp_port
//
// One frame byte is accepted per clock while the result register is free or being
// emptied. A record is formed from its last byte in the input register, then held
// in the result register. Reset clears the offset counter, header lengths, reject
// flag and both valid flags and loads the tunnel port with 4789. While a record waits
// on m_axis the input register holds its byte, so input backs up by at most one beat.
module vxlan_inner_flow_parser_unit #(
	parameter int unsigned MAX_FRAME_BYTES = vifp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [15:0]                         cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,   // frame_byte
	input  logic                                s_axis_tlast,   // frame_end
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// outer_src_addr, outer_dst_addr, outer_port_pair, net_id, inner_proto,
	// inner_src_addr, inner_dst_addr, inner_src_port, inner_dst_port,
	// frame_length, inner_length
	output logic [vifp_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
	output logic [0:0]                          m_axis_tuser    // inner_is_v6
);
	import vifp_pkg::*;

	logic         port_q;
	logic [15:0]  tunnel_port_q;
	logic         in_valid_s1, in_last_s1;
	logic [7:0]   in_byte_s1;
	logic         out_valid_s2, out_v6_s2;
	vifp_result_t res_s2, res;
	vifp_frame_t  frame;
	logic         adv, step, ok, v6;

	// Tunnel port register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunnel_port_q <= TUNNEL_PORT_RST;
		end else if (cfg_we) begin
			tunnel_port_q <= cfg_wdata;
		end
	end

	assign port_q = 1'b0;

	// Pipeline advances whenever the result slot is free or being emptied
	assign adv           = !out_valid_s2 || m_axis_tready;
	assign step          = in_valid_s1 && adv;
	assign s_axis_tready = !in_valid_s1 || adv;

	// Input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_last_s1 <= s_axis_tlast;
		end
	end

	vifp_field_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.frame_byte(in_byte_s1),
		.frame_end (in_last_s1),
		.frame     (frame)
	);

	vifp_frame_check u_check (
		.frame          (frame),
		.tunnel_udp_port(tunnel_port_q),
		.ok             (ok),
		.res            (res),
		.inner_is_v6    (v6)
	);

	// Result register: load on a good last byte, drop on handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step && in_last_s1 && ok) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_last_s1 && ok) begin
			res_s2    <= res;
			out_v6_s2 <= v6 | port_q;
		end
	end

	assign m_axis_tvalid   = out_valid_s2;
	assign m_axis_tdata    = res_s2;
	assign m_axis_tuser[0] = out_v6_s2;

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_last_s1 && ok |=> out_valid_s2)
		else $error("good frame gave no record");

	a_record_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> res_s2.frame_length >= MIN_OUTER_BYTES &&
		res_s2.inner_length < res_s2.frame_length)
		else $error("record lengths inconsistent");

	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step && !in_last_s1 |=> out_valid_s2 == ($past(out_valid_s2) && !$past(m_axis_tready)))
		else $error("record produced mid frame");

endmodule

// ----- test/tb_vxlan_inner_flow_parser_unit.sv -----
// Testbench for vxlan_inner_flow_parser_unit: streams VXLAN frames byte by byte and checks
// every flow record against a built-in byte-level parser model.
// Depends on vifp_pkg and the vxlan_inner_flow_parser_unit RTL.
`timescale 1ns / 1ps

module tb_vxlan_inner_flow_parser_unit;
	import vifp_pkg::*;

	localparam int unsigned MAX_BYTES     = MAX_FRAME_BYTES_DEF;
	localparam int unsigned LONG_FRAME    = 65600;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned MAX_PRINTED   = 20;
	localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
	localparam logic [7:0]  IP_PROTO_ICMP = 8'd1;
	localparam logic [7:0]  IP_PROTO_NONE = 8'd59;

	typedef struct {
		vifp_result_t rec;
		logic         v6;
	} flow_expect_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [15:0]            cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	// parser model state
	int unsigned  frame_pos;
	int unsigned  outer_hlen;
	int unsigned  inner_hlen;
	bit           ihl_bad;
	vifp_fields_t cap;
	logic [15:0]  tunnel_port;

	flow_expect_t pending_flows[$];
	logic [7:0]   frame_q[$];

	int unsigned n_frames;
	int unsigned n_bytes;
	int unsigned n_expected;
	int unsigned n_records;
	int unsigned n_errors;
	int unsigned stall_cycles;
	int unsigned hold_requests;
	int unsigned burst_left;
	bit          tx_steady;

	vxlan_inner_flow_parser_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // frame_byte
		.s_axis_tlast  (s_axis_tlast),   // frame_end
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// outer_src_addr, outer_dst_addr, outer_port_pair, net_id, inner_proto,
		// inner_src_addr, inner_dst_addr, inner_src_port, inner_dst_port,
		// frame_length, inner_length
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)    // inner_is_v6
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic void clear_frame_state();
		frame_pos  = 0;
		outer_hlen = 0;
		inner_hlen = 0;
		ihl_bad    = 1'b0;
		cap        = '0;
	endfunction

	function automatic bit in_span(int unsigned idx, int unsigned start, int unsigned len);
		return idx >= start && idx < start + len;
	endfunction

	// Consume one frame byte; on the last byte decide whether a flow record comes out
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output flow_expect_t r);
		int unsigned idx, u, e, ii, l, n, span_len;
		logic [31:0] ilen;
		bit ok, v6;
		logic [7:0] proto;
		logic [31:0] isrc, idst;
		logic [15:0] psrc, pdst;
		r.rec = '0;
		r.v6 = 1'b0;
		idx = frame_pos;
		if (idx < MAX_BYTES) begin
			if (idx == 14) begin
				outer_hlen = b[3:0] * 4;
				if (b[3:0] < IHL_MIN) ihl_bad = 1'b1;
			end
			u = 14 + outer_hlen;
			e = u + 16;
			ii = e + 14;
			if (idx == ii) begin
				inner_hlen = b[3:0] * 4;
				if (cap.itype == ETH_TYPE_IPV4 && b[3:0] < IHL_MIN) ihl_bad = 1'b1;
			end
			l = ii + inner_hlen;

			// capture big-endian header fields at their offsets
			if (in_span(idx, 12, 2)) cap.otype[(13 - idx) * 8 +: 8] = b;
			if (idx == 23) cap.oproto = b;
			if (in_span(idx, 26, 4)) cap.osrc[(29 - idx) * 8 +: 8] = b;
			if (in_span(idx, 30, 4)) cap.odst[(33 - idx) * 8 +: 8] = b;
			if (in_span(idx, u, 4)) cap.ports[(u + 3 - idx) * 8 +: 8] = b;
			if (in_span(idx, u + 12, 3)) cap.vni[(u + 14 - idx) * 8 +: 8] = b;
			if (in_span(idx, e + 12, 2)) cap.itype[(e + 13 - idx) * 8 +: 8] = b;
			if (idx == ii + 9) cap.v4proto = b;
			if (idx == ii + 6) cap.v6proto = b;
			if (in_span(idx, ii + 12, 4)) cap.isrc[(ii + 15 - idx) * 8 +: 8] = b;
			if (in_span(idx, ii + 16, 4)) cap.idst[(ii + 19 - idx) * 8 +: 8] = b;
			if (in_span(idx, l, 4)) cap.l4ports[(l + 3 - idx) * 8 +: 8] = b;
			frame_pos = idx + 1;
		end
		if (!last) return 1'b0;

		// end of frame: validate the header chain
		n = frame_pos;
		u = 14 + outer_hlen;
		e = u + 16;
		ii = e + 14;
		l = ii + inner_hlen;
		ok = !ihl_bad && n >= 34 && cap.otype == ETH_TYPE_IPV4 &&
			cap.oproto == IP_PROTO_UDP && n >= u + 8 &&
			(cap.ports[31:16] == tunnel_port || cap.ports[15:0] == tunnel_port) &&
			n >= e + 14;
		v6 = 1'b0;
		proto = '0;
		isrc = '0;
		idst = '0;
		psrc = '0;
		pdst = '0;
		if (ok) begin
			if (cap.itype == ETH_TYPE_IPV4) begin
				if (n < ii + 20) begin
					ok = 1'b0;
				end else begin
					proto = cap.v4proto;
					isrc = cap.isrc;
					idst = cap.idst;
					if (proto == IP_PROTO_TCP || proto == IP_PROTO_UDP) begin
						span_len = (proto == IP_PROTO_TCP) ? 20 : 8;
						if (n < l + span_len) begin
							ok = 1'b0;
						end else begin
							psrc = cap.l4ports[31:16];
							pdst = cap.l4ports[15:0];
						end
					end
				end
			end else if (cap.itype == ETH_TYPE_IPV6) begin
				if (n < ii + 40) begin
					ok = 1'b0;
				end else begin
					v6 = 1'b1;
					proto = cap.v6proto;
				end
			end else begin
				ok = 1'b0;
			end
		end

		if (ok) begin
			ilen = n - e;
			r.rec.outer_src_addr  = cap.osrc;
			r.rec.outer_dst_addr  = cap.odst;
			r.rec.outer_port_pair = cap.ports;
			r.rec.net_id          = cap.vni;
			r.rec.inner_proto     = proto;
			r.rec.inner_src_addr  = isrc;
			r.rec.inner_dst_addr  = idst;
			r.rec.inner_src_port  = psrc;
			r.rec.inner_dst_port  = pdst;
			r.rec.frame_length    = n[15:0];
			r.rec.inner_length    = ilen[15:0];
			r.v6                  = v6;
		end
		clear_frame_state();
		return ok;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_flow_record();
		vifp_result_t got;
		flow_expect_t want;
		got = m_axis_tdata;
		n_records++;
		if (pending_flows.size() == 0) begin
			report_mismatch("record with nothing pending, outer_src_addr",
				got.outer_src_addr, '0);
			return;
		end
		want = pending_flows.pop_front();
		if (got.outer_src_addr !== want.rec.outer_src_addr)
			report_mismatch("outer_src_addr", got.outer_src_addr, want.rec.outer_src_addr);
		if (got.outer_dst_addr !== want.rec.outer_dst_addr)
			report_mismatch("outer_dst_addr", got.outer_dst_addr, want.rec.outer_dst_addr);
		if (got.outer_port_pair !== want.rec.outer_port_pair)
			report_mismatch("outer_port_pair", got.outer_port_pair, want.rec.outer_port_pair);
		if (got.net_id !== want.rec.net_id)
			report_mismatch("net_id", got.net_id, want.rec.net_id);
		if (m_axis_tuser[0] !== want.v6)
			report_mismatch("inner_is_v6", m_axis_tuser[0], want.v6);
		if (got.inner_proto !== want.rec.inner_proto)
			report_mismatch("inner_proto", got.inner_proto, want.rec.inner_proto);
		if (got.inner_src_addr !== want.rec.inner_src_addr)
			report_mismatch("inner_src_addr", got.inner_src_addr, want.rec.inner_src_addr);
		if (got.inner_dst_addr !== want.rec.inner_dst_addr)
			report_mismatch("inner_dst_addr", got.inner_dst_addr, want.rec.inner_dst_addr);
		if (got.inner_src_port !== want.rec.inner_src_port)
			report_mismatch("inner_src_port", got.inner_src_port, want.rec.inner_src_port);
		if (got.inner_dst_port !== want.rec.inner_dst_port)
			report_mismatch("inner_dst_port", got.inner_dst_port, want.rec.inner_dst_port);
		if (got.frame_length !== want.rec.frame_length)
			report_mismatch("frame_length", got.frame_length, want.rec.frame_length);
		if (got.inner_length !== want.rec.inner_length)
			report_mismatch("inner_length", got.inner_length, want.rec.inner_length);
	endtask

	// Check each record beat at the edge it is accepted
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) check_flow_record();
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("FAIL vxlan_inner_flow_parser_unit");
			$finish;
		end
	end

	// Record sink: switch between stall patterns, honor long hold requests
	initial begin : record_sink
		int unsigned mode, mode_left, cyc, hold_left, holds_done;
		m_axis_tready = 1'b0;
		mode = 0;
		mode_left = 0;
		cyc = 0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(30, 300);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (cyc % 7) < 4;
					default: m_axis_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Byte sender and frame builder
	// ------------------------------------------------------------------

	task automatic send_byte(input logic [7:0] b, input logic last);
		flow_expect_t rec;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_bytes++;
		if (parse_byte(b, last, rec)) begin
			pending_flows.push_back(rec);
			n_expected++;
		end
	endtask

	task automatic idle_gap(input int unsigned cycles);
		if (cycles == 0) return;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Send frame_q in bursts, with random gaps between them unless tx_steady is set
	task automatic send_frame();
		int unsigned k;
		if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
		for (k = 0; k < frame_q.size(); k++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				if (!tx_steady) idle_gap($urandom_range(0, 6));
			end
			burst_left--;
			send_byte(frame_q[k], k == frame_q.size() - 1);
		end
		n_frames++;
	endtask

	// Drop valid and hold until every pending record has come out
	task automatic wait_for_records();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_flows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tunnel_port(input logic [15:0] port);
		wait_for_records();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= port;
		@(negedge clk);
		cfg_we <= 1'b0;
		tunnel_port = port;
	endtask

	task automatic put_random(input int unsigned count);
		repeat (count) frame_q.push_back(8'($urandom));
	endtask

	task automatic put16(input logic [15:0] v);
		frame_q.push_back(v[15:8]);
		frame_q.push_back(v[7:0]);
	endtask

	// Outer Ethernet/IPv4/UDP, VXLAN, inner Ethernet and inner L3/L4, then payload
	task automatic build_frame(input logic [3:0] oihl, input logic [15:0] etype,
			input logic [7:0] oproto, input logic [15:0] sport, input logic [15:0] dport,
			input logic [15:0] itype, input logic [3:0] iihl, input logic [7:0] iproto,
			input int unsigned pay);
		int unsigned hlen, base;
		frame_q.delete();
		put_random(12);
		put16(etype);
		hlen = (oihl < IHL_MIN) ? 20 : oihl * 4;
		base = frame_q.size();
		frame_q.push_back({4'h4, oihl});
		put_random(hlen - 1);
		frame_q[base + 9] = oproto;
		put16(sport);
		put16(dport);
		put_random(4);
		frame_q.push_back(8'h08);
		put_random(7);
		put_random(12);
		put16(itype);
		if (itype == ETH_TYPE_IPV4) begin
			hlen = (iihl < IHL_MIN) ? 20 : iihl * 4;
			base = frame_q.size();
			frame_q.push_back({4'h4, iihl});
			put_random(hlen - 1);
			frame_q[base + 9] = iproto;
			if (iproto == IP_PROTO_TCP) put_random(20);
			else if (iproto == IP_PROTO_UDP) put_random(8);
		end else if (itype == ETH_TYPE_IPV6) begin
			base = frame_q.size();
			frame_q.push_back({4'h6, 4'($urandom)});
			put_random(39);
			frame_q[base + 6] = iproto;
		end
		put_random(pay);
	endtask

	task automatic truncate_frame(input int unsigned keep);
		while (frame_q.size() > keep) void'(frame_q.pop_back());
	endtask

	task automatic run_frame(input logic [3:0] oihl, input logic [15:0] etype,
			input logic [7:0] oproto, input logic [15:0] sport, input logic [15:0] dport,
			input logic [15:0] itype, input logic [3:0] iihl, input logic [7:0] iproto,
			input int unsigned pay, input int unsigned keep);
		build_frame(oihl, etype, oproto, sport, dport, itype, iihl, iproto, pay);
		if (keep != 0) truncate_frame(keep);
		send_frame();
	endtask

	function automatic logic [3:0] pick_ihl();
		return ($urandom_range(0, 9) < 7) ? IHL_MIN : 4'($urandom_range(6, 15));
	endfunction

	// Tunnel frame with random content; the inner EtherType may also be ARP
	task automatic build_tunnel_frame();
		logic [15:0] sport, dport, itype;
		logic [7:0] iproto;
		int unsigned pick;
		sport = 16'($urandom);
		dport = 16'($urandom);
		case ($urandom_range(0, 2))
			0: sport = tunnel_port;
			1: dport = tunnel_port;
			default: begin
				sport = tunnel_port;
				dport = tunnel_port;
			end
		endcase
		pick = $urandom_range(0, 9);
		itype = (pick < 6) ? ETH_TYPE_IPV4 : (pick < 9) ? ETH_TYPE_IPV6 : ETH_TYPE_ARP;
		pick = $urandom_range(0, 3);
		iproto = (pick == 0) ? IP_PROTO_UDP : (pick == 1) ? IP_PROTO_TCP :
			(pick == 2) ? IP_PROTO_ICMP : 8'($urandom);
		build_frame(pick_ihl(), ETH_TYPE_IPV4, IP_PROTO_UDP, sport, dport, itype, pick_ihl(),
			iproto, $urandom_range(0, 40));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_header_cases();
		logic [15:0] p;
		p = tunnel_port;
		// inner protocols and port match on either side
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1234, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			10, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, p, 16'd80, ETH_TYPE_IPV4, 5, IP_PROTO_TCP,
			0, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, p, p, ETH_TYPE_IPV4, 5, IP_PROTO_ICMP, 3, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd9, p, ETH_TYPE_IPV6, 0, IP_PROTO_TCP,
			30, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, p, 16'd9, ETH_TYPE_IPV6, 0, IP_PROTO_NONE,
			0, 0);
		// no tunnel port on either side
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, p + 16'd1, p - 16'd1, ETH_TYPE_IPV4, 5,
			IP_PROTO_UDP, 0, 0);
		// longest options, outer and inner, then medium-length options
		run_frame(15, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'hFFFF, p, ETH_TYPE_IPV4, 15,
			IP_PROTO_TCP, 5, 0);
		run_frame(6, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'h0000, p, ETH_TYPE_IPV4, 9,
			IP_PROTO_UDP, 0, 0);
		// short IHL, outer and inner
		run_frame(4, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 0);
		run_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 3, IP_PROTO_UDP,
			0, 0);
		// wrong outer type, outer protocol, inner type
		run_frame(5, ETH_TYPE_IPV6, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_TCP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 0);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_ARP, 5, IP_PROTO_UDP,
			20, 0);
		// truncation in outer IPv4 and inner headers; a UDP inner header just fits
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 33);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 63);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 83);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_TCP,
			0, 103);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV4, 5, IP_PROTO_UDP,
			0, 92);
		run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd1, p, ETH_TYPE_IPV6, 5, IP_PROTO_UDP,
			0, 103);
		// one-byte frame, all-ones and all-zeros frames
		frame_q.delete();
		put_random(1);
		send_frame();
		frame_q.delete();
		repeat (100) frame_q.push_back(8'hFF);
		send_frame();
		frame_q.delete();
		repeat (100) frame_q.push_back(8'h00);
		send_frame();
		wait_for_records();
	endtask

	// Tunnel port values, extremes included: match as source, as destination, and a near miss
	task automatic test_tunnel_port();
		logic [15:0] ports [4];
		int unsigned k;
		ports[0] = 16'h0000;
		ports[1] = 16'hFFFF;
		ports[2] = 16'($urandom);
		ports[3] = TUNNEL_PORT_RST;
		for (k = 0; k < 4; k++) begin
			write_tunnel_port(ports[k]);
			run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, ports[k], 16'h1234, ETH_TYPE_IPV4, 5,
				IP_PROTO_UDP, 4, 0);
			run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'h1234, ports[k], ETH_TYPE_IPV6, 5,
				IP_PROTO_TCP, 4, 0);
			run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, ports[k] + 16'd1, ports[k] + 16'd1,
				ETH_TYPE_IPV4, 5, IP_PROTO_UDP, 4, 0);
		end
		wait_for_records();
	endtask

	// Frame longer than the byte counter: lengths saturate, later bytes are ignored
	task automatic test_long_frame();
		build_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'd7, tunnel_port, ETH_TYPE_IPV4, 5,
			IP_PROTO_TCP, 0);
		put_random(LONG_FRAME - frame_q.size());
		tx_steady = 1'b1;
		send_frame();
		wait_for_records();
	endtask

	// Sink holds off while frames keep coming, so the parser must stall its input
	task automatic test_backpressure();
		wait_for_records();
		hold_requests++;
		tx_steady = 1'b1;
		repeat (5) begin
			run_frame(5, ETH_TYPE_IPV4, IP_PROTO_UDP, 16'($urandom), tunnel_port,
				ETH_TYPE_IPV4, 5, IP_PROTO_UDP, $urandom_range(0, 30), 0);
		end
		wait_for_records();
	endtask

	task automatic test_random_traffic();
		int unsigned bytes0, exp0, frames, kind, pick;
		bytes0 = n_bytes;
		exp0 = n_expected;
		frames = 0;
		while (n_bytes < bytes0 + 1000 || n_expected < exp0 + 60) begin
			// retune the tunnel port now and then, extremes included
			if (frames % 50 == 49) begin
				pick = $urandom_range(0, 3);
				write_tunnel_port((pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
					(pick == 2) ? TUNNEL_PORT_RST : 16'($urandom));
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				build_tunnel_frame();
			end else if (kind < 80) begin
				build_tunnel_frame();
				truncate_frame($urandom_range(1, frame_q.size()));
			end else if (kind < 88) begin
				build_tunnel_frame();
				frame_q[$urandom_range(0, 90)] = 8'($urandom);
			end else if (kind < 95) begin
				frame_q.delete();
				put_random($urandom_range(1, 120));
			end else begin
				build_tunnel_frame();
				frame_q[14] = {4'h4, 4'($urandom_range(0, 4))};
			end
			send_frame();
			frames++;
			if ($urandom_range(0, 19) == 0) wait_for_records();
		end
		wait_for_records();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		n_frames      = 0;
		n_bytes       = 0;
		n_expected    = 0;
		n_records     = 0;
		n_errors      = 0;
		stall_cycles  = 0;
		hold_requests = 0;
		burst_left    = 0;
		tx_steady     = 1'b0;
		tunnel_port   = TUNNEL_PORT_RST;
		clear_frame_state();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_header_cases();
		test_tunnel_port();
		test_long_frame();
		test_backpressure();
		test_random_traffic();
		wait_for_records();

		$display("covered %0d frames / %0d bytes, %0d flow records checked, %0d mismatches",
			n_frames, n_bytes, n_records, n_errors);
		$display("tunnel ports 0, ffff and default, IHL and truncation rejects, one long frame");
		if (n_errors == 0)
			$display("PASS vxlan_inner_flow_parser_unit");
		else
			$display("FAIL vxlan_inner_flow_parser_unit");
		$finish;
	end

endmodule
